// ===== sv/carv_pkg.sv =====
// ----------------------------------------------------------------------------
// carv_pkg
// Shared constants, helper functions and delay-line tables for the comb/allpass reverb.
// ----------------------------------------------------------------------------
package carv_pkg;

   localparam int RateScaleQ8Default = 256;
   localparam int CombCount          = 8;
   localparam int AllpassCount       = 4;
   localparam int CsrIndexWidth      = 2;
   localparam int CsrDataWidth       = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_ROOM   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DAMP   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MIX    = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SMOOTH = 2'd3;

   // Base tunings in samples at the reference rate
   function automatic int comb_tuning(input int k);
      int t;
      unique case (k)
         0: t = 1116;
         1: t = 1188;
         2: t = 1277;
         3: t = 1356;
         4: t = 1422;
         5: t = 1491;
         6: t = 1557;
         default: t = 1617;
      endcase
      return t;
   endfunction

   function automatic int ap_tuning(input int k);
      int t;
      unique case (k)
         0: t = 556;
         1: t = 441;
         2: t = 341;
         default: t = 225;
      endcase
      return t;
   endfunction

   function automatic int dlen(input int t, input int scale);
      return (t * scale) / 256 + 1;
   endfunction

   function automatic int comb_base(input int k, input int scale);
      int b;
      b = 0;
      for (int i = 0; i < CombCount; i++) if (i < k) b += dlen(comb_tuning(i), scale);
      return b;
   endfunction

   function automatic int ap_base(input int k, input int scale);
      int b;
      b = 0;
      for (int i = 0; i < AllpassCount; i++) if (i < k) b += dlen(ap_tuning(i), scale);
      return b;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== sv/comb_allpass_reverb_unit.sv =====
// ----------------------------------------------------------------------------
// comb_allpass_reverb_unit
// Mono comb/allpass reverb with smoothed room, damping and mix controls.
// ----------------------------------------------------------------------------
// Usage:
//  Input items (req_sample_in, req_block_end) enter on req_valid when
//  req_stall is low. One result item leaves on rsp_valid per input item,
//  taken when rsp_stall is low. csr_* writes set the four target registers
//  and are taken in any cycle (write only while idle).
//  Each item runs through a sequencer that drives one shared multiplier:
//  three smoothing steps (product, then update), three control and gain
//  steps, four steps per comb (read, lowpass product, feedback product,
//  write) for 8 combs, two steps per allpass stage (read, write) for 4
//  stages, five mix steps and one output step. The next item is taken
//  only once the sequencer is back in idle after the output step, so items
//  do not overlap. The single multiplier and the single memory port of
//  each delay store set this pace.
//  After reset the delay stores are cleared, one word per cycle, over
//  every word of the comb store (11032 at the default rate scale);
//  req_stall stays high meanwhile. If the receiver stalls, the result is
//  held and the next item is accepted but waits before delivery.
// ----------------------------------------------------------------------------
module comb_allpass_reverb_unit #(
   parameter int RATE_SCALE_Q8 = carv_pkg::RateScaleQ8Default
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [23:0]                     req_sample_in,
   input  logic                                   req_block_end,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [23:0]                     rsp_sample_out,
   output logic                                   rsp_block_end_out,
   input  logic                                   csr_write_en,
   input  logic [carv_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [carv_pkg::CsrDataWidth-1:0]      csr_write_data
);
   import carv_pkg::*;

   localparam int CombDepth = comb_base(CombCount, RATE_SCALE_Q8);
   localparam int ApDepth   = ap_base(AllpassCount, RATE_SCALE_Q8);
   localparam int CombAw    = $clog2(CombDepth);
   localparam int ApAw      = $clog2(ApDepth);
   localparam int CPW       = $clog2(dlen(1617, RATE_SCALE_Q8) + 1);
   localparam int APW       = $clog2(dlen(556, RATE_SCALE_Q8) + 1);

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_SM    = 14'b00000000000010,  // smoothing products, step by idx
      S_SMW   = 14'b00000000000100,
      S_FB    = 14'b00000000001000,
      S_DMP   = 14'b00000000010000,
      S_INJ   = 14'b00000000100000,
      S_CRD   = 14'b00000001000000,  // comb read issued
      S_CLP   = 14'b00000010000000,  // lowpass product
      S_CFB   = 14'b00000100000000,  // feedback product
      S_CWR   = 14'b00001000000000,
      S_ARD   = 14'b00010000000000,
      S_AWR   = 14'b00100000000000,
      S_MX    = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // Registers
   logic [15:0] room_ff, damp_ff, mix_ff, coef_ff;
   logic [23:0] sm_ff [3];
   logic [23:0] sm_in [3];
   logic [15:0] lag_ff, lag_in, fb_ff, fb_in, d_ff, d_in;
   logic [2:0]  idx_ff, idx_in;
   logic signed [23:0] x_ff;
   logic        be_ff;
   logic signed [31:0] inj_ff, inj_in, w_ff, w_in;
   logic signed [34:0] wet_ff, wet_in;
   logic signed [31:0] lp_ff [CombCount];
   logic signed [31:0] lp_in [CombCount];
   logic [CPW-1:0] cpos_ff [CombCount];
   logic [CPW-1:0] cpos_in [CombCount];
   logic [APW-1:0] apos_ff [AllpassCount];
   logic [APW-1:0] apos_in [AllpassCount];
   logic signed [57:0] acc_ff, acc_in;
   logic        rv_ff, rv_in;
   logic signed [23:0] ro_ff, ro_in;
   logic        rb_ff, rb_in;

   // Shared multiplier and memories
   logic signed [33:0] op_a;
   logic signed [17:0] op_b;
   logic signed [51:0] prod;
   logic               comb_we, ap_we, clear_done;
   logic [CombAw-1:0]  comb_addr;
   logic [ApAw-1:0]    ap_addr;
   logic signed [31:0] comb_wdata, comb_rdata, ap_wdata, ap_rdata;

   carv_mac u_mac (.clock(clock), .op_a(op_a), .op_b(op_b), .prod(prod));

   carv_lines #(.CombDepth(CombDepth), .ApDepth(ApDepth), .CombAw(CombAw), .ApAw(ApAw))
   u_lines (
      .clock(clock), .reset(reset),
      .comb_we(comb_we), .comb_addr(comb_addr), .comb_wdata(comb_wdata),
      .comb_rdata(comb_rdata),
      .ap_we(ap_we), .ap_addr(ap_addr), .ap_wdata(ap_wdata), .ap_rdata(ap_rdata),
      .clear_done(clear_done)
   );

   function automatic logic [CombAw-1:0] comb_addr_of(input logic [2:0] k,
                                                      input logic [CPW-1:0] p);
      logic [CombAw-1:0] b;
      b = '0;
      for (int i = 0; i < CombCount; i++)
         if (k == 3'(i)) b = CombAw'(comb_base(i, RATE_SCALE_Q8));
      return b + CombAw'(p);
   endfunction

   function automatic logic [ApAw-1:0] ap_addr_of(input logic [1:0] k,
                                                  input logic [APW-1:0] p);
      logic [ApAw-1:0] b;
      b = '0;
      for (int i = 0; i < AllpassCount; i++)
         if (k == 2'(i)) b = ApAw'(ap_base(i, RATE_SCALE_Q8));
      return b + ApAw'(p);
   endfunction

   function automatic logic [CPW-1:0] comb_next(input logic [2:0] k, input logic [CPW-1:0] p);
      logic [CPW-1:0] l;
      l = '0;
      for (int i = 0; i < CombCount; i++)
         if (k == 3'(i)) l = CPW'(dlen(comb_tuning(i), RATE_SCALE_Q8));
      return (p + 1'b1 >= l) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [APW-1:0] ap_next(input logic [1:0] k, input logic [APW-1:0] p);
      logic [APW-1:0] l;
      l = '0;
      for (int i = 0; i < AllpassCount; i++)
         if (k == 2'(i)) l = APW'(dlen(ap_tuning(i), RATE_SCALE_Q8));
      return (p + 1'b1 >= l) ? '0 : p + 1'b1;
   endfunction

   logic [15:0] sm_reg;
   logic signed [52:0] rnd;
   logic signed [33:0] sm_sum, lp_sum, cw_sum;
   logic signed [31:0] b_half, w_half;
   logic               accept, rsp_take;

   assign accept    = req_valid && !req_stall;
   assign rsp_take  = rv_ff && !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE) || !clear_done;

   // Target register for the current smoothing step
   always_comb begin
      unique case (idx_ff[1:0])
         2'd0:    sm_reg = room_ff;
         2'd1:    sm_reg = damp_ff;
         default: sm_reg = mix_ff;
      endcase
   end

   assign rnd    = 53'(prod) + 53'sd32768;
   assign b_half = ap_rdata >>> 1;
   assign w_half = w_ff >>> 1;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      sm_in = sm_ff;
      lag_in = lag_ff; fb_in = fb_ff; d_in = d_ff;
      idx_in = idx_ff;
      inj_in = inj_ff; wet_in = wet_ff; w_in = w_ff;
      lp_in = lp_ff; cpos_in = cpos_ff; apos_in = apos_ff;
      acc_in = acc_ff;
      rv_in = rv_ff; ro_in = ro_ff; rb_in = rb_ff;
      op_a = '0; op_b = '0;
      comb_we = 1'b0; ap_we = 1'b0;
      comb_addr = comb_addr_of(idx_ff, cpos_ff[idx_ff]);
      ap_addr   = ap_addr_of(idx_ff[1:0], apos_ff[idx_ff[1:0]]);
      comb_wdata = '0; ap_wdata = '0;
      sm_sum = '0; lp_sum = '0; cw_sum = '0;
      if (rsp_take) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept) state_in = S_SM;
         end
         S_SM: begin
            // k*(target - s)
            op_a = 34'($signed({1'b0, sm_reg, 8'h00}) - $signed({1'b0, sm_ff[idx_ff[1:0]]}));
            op_b = 18'($signed({1'b0, coef_ff}));
            state_in = S_SMW;
         end
         S_SMW: begin
            sm_sum = 34'($signed({1'b0, sm_ff[idx_ff[1:0]]})) + 34'(rnd >>> 16);
            if (sm_sum < 0) sm_in[idx_ff[1:0]] = '0;
            else if (sm_sum > 34'sh0FFFFFF) sm_in[idx_ff[1:0]] = 24'hFFFFFF;
            else sm_in[idx_ff[1:0]] = sm_sum[23:0];
            if (idx_ff == 3'd2) begin
               idx_in = '0;
               state_in = S_FB;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SM;
            end
         end
         S_FB: begin
            // issue 0.7*room, then 0.4*damp, then input gain; products come back through the multiplier register
            op_a = 34'($signed({1'b0, sm_ff[0]}));
            op_b = 18'sd45875;
            state_in = S_DMP;
         end
         S_DMP: begin
            fb_in = 16'(17'd19661 + 17'(prod >>> 24) > 17'd65535 ? 17'd65535
                                : 17'd19661 + 17'(prod >>> 24));
            op_a = 34'($signed({1'b0, sm_ff[1]}));
            op_b = 18'sd26214;
            state_in = S_INJ;
         end
         S_INJ: begin
            d_in = 16'(prod >>> 24);
            op_a = 34'(x_ff);
            op_b = 18'sd1638;
            wet_in = '0;
            idx_in = '0;
            state_in = S_CRD;
         end
         S_CRD: begin
            if (idx_ff == 3'd0) inj_in = 32'(rnd >>> 16);
            // read comb word
            state_in = S_CLP;
         end
         S_CLP: begin
            wet_in = wet_ff + 35'(comb_rdata);
            op_a = 34'(comb_rdata) - 34'(lp_ff[idx_ff]);
            op_b = 18'($signed({1'b0, d_ff}));
            state_in = S_CFB;
         end
         S_CFB: begin
            lp_sum = 34'(lp_ff[idx_ff]) + 34'(rnd >>> 16);
            lp_in[idx_ff] = sat32(lp_sum);
            op_a = 34'(sat32(lp_sum));
            op_b = 18'($signed({1'b0, lag_ff}));
            state_in = S_CWR;
         end
         S_CWR: begin
            cw_sum = 34'(inj_ff) + 34'(rnd >>> 16);
            comb_we = 1'b1;
            comb_wdata = sat32(cw_sum);
            cpos_in[idx_ff] = comb_next(idx_ff, cpos_ff[idx_ff]);
            if (idx_ff == 3'(CombCount - 1)) begin
               idx_in = '0;
               lag_in = fb_ff;
               // saturate the full comb sum to one audio word
               if (wet_ff > 35'sh0_7FFF_FFFF) w_in = 32'sh7FFF_FFFF;
               else if (wet_ff < -35'sh0_8000_0000) w_in = 32'sh8000_0000;
               else w_in = wet_ff[31:0];
               state_in = S_ARD;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_CRD;
            end
         end
         S_ARD: begin
            state_in = S_AWR;
         end
         S_AWR: begin
            ap_we = 1'b1;
            ap_wdata = sat32(34'(w_ff) + 34'(b_half));
            w_in = sat32(34'(ap_rdata) - 34'(w_half));
            apos_in[idx_ff[1:0]] = ap_next(idx_ff[1:0], apos_ff[idx_ff[1:0]]);
            if (idx_ff == 3'(AllpassCount - 1)) begin
               idx_in = '0;
               state_in = S_MX;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_ARD;
            end
         end
         S_MX: begin
            // products by idx: 0 dry high, 1 wet low, 2 dry low, 3 wet high; 4: last one lands
            if (idx_ff == 3'd0) begin
               acc_in = '0;
               idx_in = 3'd1;
               // dry: 2x*(2^24-m) split as 2x*2^24 - 2x*m
               op_a = -(34'(x_ff) <<< 1);
               op_b = 18'($signed({1'b0, sm_ff[2][23:7]}));
            end else if (idx_ff == 3'd1) begin
               acc_in = (58'(prod) <<< 7) + (58'(x_ff) <<< 25);
               op_a = 34'(w_ff) * 34'sd3;
               op_b = 18'($signed({1'b0, sm_ff[2][6:0]}));
               idx_in = 3'd2;
            end else if (idx_ff == 3'd2) begin
               acc_in = acc_ff + 58'(prod);
               op_a = -(34'(x_ff) <<< 1);
               op_b = 18'($signed({1'b0, sm_ff[2][6:0]}));
               idx_in = 3'd3;
            end else if (idx_ff == 3'd3) begin
               acc_in = acc_ff + 58'(prod);
               op_a = 34'(w_ff) * 34'sd3;
               op_b = 18'($signed({1'b0, sm_ff[2][23:7]}));
               idx_in = 3'd4;
            end else begin
               acc_in = acc_ff + (58'(prod) <<< 7);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp_take) begin
               rv_in = 1'b1;
               rb_in = be_ff;
               if ((acc_ff + 58'sd8388608) >>> 24 > 58'sd8388607) ro_in = 24'sh7FFFFF;
               else if ((acc_ff + 58'sd8388608) >>> 24 < -58'sd8388608) ro_in = 24'sh800000;
               else ro_in = 24'((acc_ff + 58'sd8388608) >>> 24);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         room_ff <= 16'd32768; damp_ff <= 16'd32768; mix_ff <= 16'd32768;
         coef_ff <= 16'd148;
         for (int i = 0; i < 3; i++) sm_ff[i] <= 24'h800000;
         lag_ff <= '0;
         for (int i = 0; i < CombCount; i++) begin
            lp_ff[i] <= '0;
            cpos_ff[i] <= '0;
         end
         for (int i = 0; i < AllpassCount; i++) apos_ff[i] <= '0;
         idx_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sm_ff <= sm_in;
         lag_ff <= lag_in;
         lp_ff <= lp_in;
         cpos_ff <= cpos_in;
         apos_ff <= apos_in;
         idx_ff <= idx_in;
         rv_ff <= rv_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_ROOM:   room_ff <= csr_write_data;
               CSR_DAMP:   damp_ff <= csr_write_data;
               CSR_MIX:    mix_ff  <= csr_write_data;
               CSR_SMOOTH: coef_ff <= csr_write_data;
               default:    ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff  <= req_sample_in;
         be_ff <= req_block_end;
      end
      fb_ff <= fb_in; d_ff <= d_in;
      inj_ff <= inj_in; wet_ff <= wet_in; w_ff <= w_in;
      acc_ff <= acc_in;
      ro_ff <= ro_in; rb_ff <= rb_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_sample_out    = ro_ff;
   assign rsp_block_end_out = rb_ff;

`ifndef SYNTHESIS
   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state corrupt");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      !clear_done |-> req_stall)
      else $error("item taken during clear pass");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff && $stable(ro_ff))
      else $error("stalled result changed");
`endif
endmodule

// ===== sv/carv_lines.sv =====
// ----------------------------------------------------------------------------
// carv_lines
// Delay-line memories for the combs and allpasses, with a clearing pass.
// ----------------------------------------------------------------------------
module carv_lines #(
   parameter int CombDepth = 11032,
   parameter int ApDepth   = 1567,
   parameter int CombAw    = 14,
   parameter int ApAw      = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     comb_we,
   input  logic [CombAw-1:0]        comb_addr,
   input  logic signed [31:0]       comb_wdata,
   output logic signed [31:0]       comb_rdata,
   input  logic                     ap_we,
   input  logic [ApAw-1:0]          ap_addr,
   input  logic signed [31:0]       ap_wdata,
   output logic signed [31:0]       ap_rdata,
   output logic                     clear_done
);
   logic signed [31:0] comb_mem [CombDepth];
   logic signed [31:0] ap_mem   [ApDepth];
   logic [CombAw:0]    clr_ff, clr_in;
   logic               busy_ff, busy_in;
   logic [CombAw-1:0]  c_a;
   logic [ApAw-1:0]    a_a;
   logic               c_w, a_w;
   logic signed [31:0] c_d, a_d;

   // Sweep both memories after reset
   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (clr_ff == (CombAw+1)'(CombDepth - 1)) busy_in = 1'b0;
         else clr_in = clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   assign clear_done = ~busy_ff;

   always_comb begin
      if (busy_ff) begin
         c_a = clr_ff[CombAw-1:0];
         c_w = 1'b1;
         c_d = '0;
         a_a = clr_ff[ApAw-1:0];
         a_w = (clr_ff < (CombAw+1)'(ApDepth));
         a_d = '0;
      end else begin
         c_a = comb_addr;
         c_w = comb_we;
         c_d = comb_wdata;
         a_a = ap_addr;
         a_w = ap_we;
         a_d = ap_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (c_w) comb_mem[c_a] <= c_d;
      comb_rdata <= comb_mem[c_a];
   end

   always_ff @(posedge clock) begin
      if (a_w) ap_mem[a_a] <= a_d;
      ap_rdata <= ap_mem[a_a];
   end

`ifndef SYNTHESIS
   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(clr_ff) == (CombAw+1)'(CombDepth - 1))
      else $error("clear pass ended early");
   a_clear_mono: assert property (@(posedge clock) disable iff (reset)
      busy_ff && $past(busy_ff) && !$past(reset) |-> clr_ff == $past(clr_ff) + 1'b1)
      else $error("clear counter skipped");
   a_no_reenter: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |=> !busy_ff)
      else $error("clear pass restarted");
`endif
endmodule

// ===== sv/carv_mac.sv =====
// ----------------------------------------------------------------------------
// carv_mac
// Shared multiply unit: 34x18 signed product, registered.
// ----------------------------------------------------------------------------
module carv_mac (
   input  logic                clock,
   input  logic signed [33:0]  op_a,
   input  logic signed [17:0]  op_b,
   output logic signed [51:0]  prod
);
   // Register the product
   always_ff @(posedge clock) begin
      prod <= 52'(op_a * op_b);
   end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for comb_allpass_reverb_unit: a bit-exact predictor of
// the smoothed controls, comb and allpass delay lines and wet/dry mix checks
// every output item in order, across register settings and idling phases.
// ----------------------------------------------------------------------------
module tb_top;
   import carv_pkg::*;

   localparam int Scale     = RateScaleQ8Default;
   localparam int CombWords = comb_base(CombCount, Scale);
   localparam int ApWords   = ap_base(AllpassCount, Scale);
   localparam int CycleCap  = 1000000;
   localparam int DrainWait = 100;

   typedef struct {
      logic signed [23:0] sample;
      logic               block_end;
   } audio_item_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [23:0]       req_sample_in;
   logic                     req_block_end;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [23:0]       rsp_sample_out;
   logic                     rsp_block_end_out;
   logic                     csr_write_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_write_data;

   comb_allpass_reverb_unit u_top (.*);

   // predictor state
   int          comb_mem [CombWords];
   int          ap_mem [ApWords];
   int          comb_pos [CombCount];
   int          ap_pos [AllpassCount];
   int          comb_lp [CombCount];
   int unsigned fb_prev;
   int unsigned ctl_s [3];
   int unsigned ctl_reg [4];

   audio_item_type expected_out[$];
   int          mismatches;
   int          items_sent;
   int          items_checked;
   int          cycles;
   int          send_idle_pct;
   int          stall_pct;
   logic        hold_rsp;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
   endfunction

   // move one control one smoothing step toward its register
   function automatic int unsigned glide(input int unsigned s, input int unsigned target);
      longint diff;
      longint n;
      diff = (longint'(target) <<< 8) - longint'(s);
      n = longint'(s) + ((longint'(ctl_reg[CSR_SMOOTH]) * diff + 32768) >>> 16);
      if (n < 0) n = 0;
      if (n > 64'hFF_FFFF) n = 64'hFF_FFFF;
      return int'(n);
   endfunction

   task automatic reverb_reset_state();
      foreach (comb_mem[i]) comb_mem[i] = 0;
      foreach (ap_mem[i]) ap_mem[i] = 0;
      foreach (comb_pos[i]) begin
         comb_pos[i] = 0;
         comb_lp[i] = 0;
      end
      foreach (ap_pos[i]) ap_pos[i] = 0;
      fb_prev = 0;
      ctl_reg[CSR_ROOM] = 32768;
      ctl_reg[CSR_DAMP] = 32768;
      ctl_reg[CSR_MIX] = 32768;
      ctl_reg[CSR_SMOOTH] = 148;
      for (int i = 0; i < 3; i++) ctl_s[i] = 32'd32768 << 8;
   endtask

   // compute one wet/dry output sample and advance the predictor
   function automatic logic signed [23:0] reverb_sample(input logic signed [23:0] x);
      longint      fb;
      longint      d;
      longint      mix;
      longint      inj;
      longint      wet;
      longint      acc;
      int          w;
      int          o;
      int          b;
      int          y;
      int          base;
      int          len;
      int          p;
      ctl_s[0] = glide(ctl_s[0], ctl_reg[CSR_ROOM]);
      ctl_s[1] = glide(ctl_s[1], ctl_reg[CSR_DAMP]);
      ctl_s[2] = glide(ctl_s[2], ctl_reg[CSR_MIX]);
      fb = 19661 + ((longint'(45875) * ctl_s[0]) >>> 24);
      if (fb > 65535) fb = 65535;
      d = (longint'(26214) * ctl_s[1]) >>> 24;
      mix = ctl_s[2];
      inj = (longint'(x) * 1638 + 32768) >>> 16;
      wet = 0;
      for (int k = 0; k < CombCount; k++) begin
         base = comb_base(k, Scale);
         len = dlen(comb_tuning(k), Scale);
         p = comb_pos[k];
         o = comb_mem[base + p];
         comb_lp[k] = clip32(longint'(comb_lp[k]) +
                             ((d * (longint'(o) - comb_lp[k]) + 32768) >>> 16));
         comb_mem[base + p] = clip32(inj +
                                     ((longint'(fb_prev) * comb_lp[k] + 32768) >>> 16));
         comb_pos[k] = (p + 1 >= len) ? 0 : p + 1;
         wet += o;
      end
      fb_prev = int'(fb);
      w = clip32(wet);
      for (int k = 0; k < AllpassCount; k++) begin
         base = ap_base(k, Scale);
         len = dlen(ap_tuning(k), Scale);
         p = ap_pos[k];
         b = ap_mem[base + p];
         y = clip32(longint'(b) - (w >>> 1));
         ap_mem[base + p] = clip32(longint'(w) + (b >>> 1));
         ap_pos[k] = (p + 1 >= len) ? 0 : p + 1;
         w = y;
      end
      acc = longint'(x) * 2 * (64'd16777216 - mix) + longint'(w) * 3 * mix;
      acc = (acc + 8388608) >>> 24;
      if (acc > 8388607) acc = 8388607;
      if (acc < -8388608) acc = -8388608;
      return acc[23:0];
   endfunction

   // offer one item, hold it until taken, then maybe idle
   task automatic send_sample(input logic signed [23:0] x, input logic be);
      audio_item_type e;
      req_valid <= 1'b1;
      req_sample_in <= x;
      req_block_end <= be;
      do @(posedge clock); while (req_stall);
      e.sample = reverb_sample(x);
      e.block_end = be;
      expected_out.insert(expected_out.size(), e);
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   // drive one register write; the caller drops the write enable
   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input int unsigned val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val[15:0];
      @(posedge clock);
      ctl_reg[idx] = val & 16'hFFFF;
   endtask

   task automatic set_regs(input int unsigned room, input int unsigned damp,
                           input int unsigned mix, input int unsigned k);
      wait_drained();
      write_reg(CSR_ROOM, room);
      write_reg(CSR_DAMP, damp);
      write_reg(CSR_MIX, mix);
      write_reg(CSR_SMOOTH, k);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic signed [23:0] random_sample();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
         1: return 24'($signed($urandom_range(8191)) - 4096);
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic send_random(input int n);
      for (int i = 0; i < n; i++) send_sample(random_sample(), $urandom_range(7) == 0);
   endtask

   // extremes of the sample, block marks, impulse and silence
   task automatic test_directed_samples();
      send_sample(24'sh7FFFFF, 1'b0);
      send_sample(-24'sh800000, 1'b1);
      send_sample(24'sd0, 1'b0);
      send_sample(-24'sd1, 1'b1);
      send_sample(24'sd1, 1'b0);
      send_sample(24'sh555555, 1'b1);
      send_sample(24'shAAAAAA, 1'b0);
      for (int i = 0; i < 6; i++) send_sample(24'sd0, i[0]);
   endtask

   // registers at both ends; instant smoothing makes controls jump
   task automatic test_register_extremes();
      set_regs(0, 0, 0, 0);
      send_random(4);
      set_regs(65535, 65535, 65535, 65535);
      send_random(6);
      set_regs(65535, 0, 65535, 30000);
      send_random(6);
      set_regs(0, 65535, 0, 1);
      send_random(4);
   endtask

   task automatic test_idle_phases();
      int pct [4][2] = '{'{0, 0}, '{56, 0}, '{0, 56}, '{22, 22}};
      for (int ph = 0; ph < 4; ph++) begin
         set_regs($urandom_range(65535), $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(4000));
         send_idle_pct = pct[ph][0];
         stall_pct = pct[ph][1];
         send_random(450);
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic hold_output(input int n);
      hold_rsp <= 1'b1;
      repeat (n) @(posedge clock);
      hold_rsp <= 1'b0;
   endtask

   // long output hold with the sender still pushing, then a full pause
   task automatic test_backpressure();
      fork
         hold_output(600);
      join_none
      send_random(40);
      wait_drained();
      send_random(20);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleCap) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // receiver: random stall plus hold; compare each taken item
   always @(posedge clock) begin
      audio_item_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_out.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected output item %0d", rsp_sample_out);
            end else begin
               e = expected_out.pop_front();
               items_checked++;
               if (rsp_sample_out !== e.sample || rsp_block_end_out !== e.block_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("item %0d: expected %0d/%0b, got %0d/%0b", items_checked,
                              e.sample, e.block_end, rsp_sample_out, rsp_block_end_out);
               end
            end
         end
         rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_in = '0;
      req_block_end = 1'b0;
      rsp_stall = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      hold_rsp = 1'b0;
      mismatches = 0;
      items_sent = 0;
      items_checked = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reverb_reset_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_samples();
      test_register_extremes();
      test_idle_phases();
      test_backpressure();
      wait_drained();

      $display("covered %0d samples (%0d checked) over register extremes,", items_sent,
               items_checked);
      $display("idle/stall phases, a long output hold and a full drain pause");
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
